@@ rtl/core/srst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srst_pkg
// Word types, codes and controller/datapath links for the range set tracker.
// ----------------------------------------------------------------------------
package srst_pkg;

    localparam int SEQ_W = 63;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_PRESENT   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_ERASED    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_REPORT    = 3'd5;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [SEQ_W-1:0] range_low;
        logic [SEQ_W-1:0] range_high;
    } req_word_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             span_valid;
        logic [SEQ_W-1:0] span_low;
        logic [SEQ_W-1:0] span_high;
        logic             last;
    } rsp_word_t;

    // controller state flags
    typedef struct packed {
        logic in_idle;
        logic in_read;
        logic in_scan;
        logic in_write2;
        logic in_tail;
        logic in_final;
    } srst_cmd_t;

    // datapath status
    typedef struct packed {
        logic start;
        logic table_empty;
        logic need_write2;
        logic next_done;
        logic idx_done;
        logic block;
    } srst_stat_t;

    function automatic rsp_word_t make_word(input logic [2:0] st, input logic vld,
                                            input logic [SEQ_W-1:0] lo,
                                            input logic [SEQ_W-1:0] hi,
                                            input logic lst);
        rsp_word_t w;
        w.status     = st;
        w.span_valid = vld;
        w.span_low   = vld ? lo : '0;
        w.span_high  = vld ? hi : '0;
        w.last       = lst;
        return w;
    endfunction

endpackage

@@ rtl/core/srst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srst_ctrl
// Sequencer: accept, per-entry read/scan/second write, tail and final word.
// ----------------------------------------------------------------------------
module srst_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  srst_pkg::srst_stat_t st,
    output srst_pkg::srst_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_WRITE2,
        S_TAIL,
        S_FINAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (st.start)
                begin
                    state_next = st.table_empty ? S_TAIL : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!st.block)
                begin
                    if (st.need_write2)
                    begin
                        state_next = S_WRITE2;
                    end
                    else
                    begin
                        state_next = st.next_done ? S_TAIL : S_READ;
                    end
                end
            end
            S_WRITE2:
            begin
                state_next = st.idx_done ? S_TAIL : S_READ;
            end
            S_TAIL:
            begin
                if (!st.block)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (!st.block)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.in_idle   = (state_reg == S_IDLE);
        cmd.in_read   = (state_reg == S_READ);
        cmd.in_scan   = (state_reg == S_SCAN);
        cmd.in_write2 = (state_reg == S_WRITE2);
        cmd.in_tail   = (state_reg == S_TAIL);
        cmd.in_final  = (state_reg == S_FINAL);
    end

endmodule

@@ rtl/core/srst_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srst_dpath
// Two-bank range table, scan arithmetic, pending word and output register.
// ----------------------------------------------------------------------------
module srst_dpath
#(
    parameter int MAX_RANGES = 16,
    parameter int SEQ_BITS   = 63
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  srst_pkg::srst_cmd_t  cmd,
    output srst_pkg::srst_stat_t st,
    input  logic                 req_valid,
    input  srst_pkg::req_word_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output srst_pkg::rsp_word_t  rsp
);

    localparam int SB = SEQ_BITS;
    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int AW = IW + 1;
    localparam int EW = 2 * SB;
    localparam logic [SB-1:0] SEQ_TOP = {SB{1'b1}};
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

    // bank select in the top address bit
    logic [EW-1:0] tbl_mem [0:(2**AW)-1];
    logic [EW-1:0] rd_reg;

    logic [1:0]    op_reg;
    logic [SB-1:0] lo_reg, hi_reg, cur_reg, newlo_reg, newhi_reg, prev_reg;
    logic          more_reg, touched_reg, merged_reg, found_reg, split_reg;
    logic [CW-1:0] idx_reg, wptr_reg, cnt_reg;
    logic          bank_reg;
    logic          pend_valid_reg;
    srst_pkg::rsp_word_t pend_reg;
    logic          out_valid_reg;
    srst_pkg::rsp_word_t out_reg;
    logic [EW-1:0] wr2_reg;

    logic [SB-1:0] sl, sh, in_lo, in_hi, lo_s, hi_s;
    logic          t_a, t_b;
    logic          gap_en;
    logic [SB-1:0] gap_lo, gap_hi;
    logic          wr1_en, wr2_en;
    logic [EW-1:0] wr1_data, wr2_data;
    logic [SB-1:0] cur_next, newlo_next, newhi_next;
    logic          more_next, touched_next, merged_next, found_next, split_next;
    logic          out_free, block, go_scan, go_tail, go_final, accept;
    logic          ins_full, commit;
    logic [2:0]    gap_status;
    srst_pkg::rsp_word_t final_word, push_word;
    logic          push;

    assign sl    = rd_reg[EW-1:SB];
    assign sh    = rd_reg[SB-1:0];
    assign in_lo = req.range_low[SB-1:0];
    assign in_hi = req.range_high[SB-1:0];
    assign lo_s  = (req.opcode == srst_pkg::OP_INSERT && in_hi < in_lo) ? in_hi : in_lo;
    assign hi_s  = (req.opcode == srst_pkg::OP_INSERT && in_hi < in_lo) ? in_lo : in_hi;

    assign t_a = (lo_reg == '0) || (sh >= lo_reg - 1'b1);
    assign t_b = (hi_reg == SEQ_TOP) || (sl <= hi_reg + 1'b1);

    assign gap_status = (op_reg == srst_pkg::OP_INSERT) ? srst_pkg::ST_INSERTED
                                                        : srst_pkg::ST_REPORT;

    always_comb
    begin
        gap_en       = 1'b0;
        gap_lo       = cur_reg;
        gap_hi       = hi_reg;
        wr1_en       = 1'b0;
        wr2_en       = 1'b0;
        wr1_data     = rd_reg;
        wr2_data     = rd_reg;
        cur_next     = cur_reg;
        more_next    = more_reg;
        newlo_next   = newlo_reg;
        newhi_next   = newhi_reg;
        touched_next = touched_reg;
        merged_next  = merged_reg;
        found_next   = found_reg;
        split_next   = split_reg;
        if (cmd.in_scan)
        begin
            case (op_reg)
                srst_pkg::OP_INSERT:
                begin
                    if (!t_a)
                    begin
                        wr1_en = 1'b1;
                    end
                    else if (t_b)
                    begin
                        // entry overlaps or touches the new range
                        if (more_reg && sl > cur_reg && cur_reg <= hi_reg)
                        begin
                            gap_en = 1'b1;
                            gap_lo = cur_reg;
                            gap_hi = (sl - 1'b1 < hi_reg) ? sl - 1'b1 : hi_reg;
                        end
                        if (more_reg && sh >= cur_reg)
                        begin
                            if (sh == SEQ_TOP)
                            begin
                                more_next = 1'b0;
                            end
                            else
                            begin
                                cur_next = sh + 1'b1;
                            end
                        end
                        if (sl < newlo_reg)
                        begin
                            newlo_next = sl;
                        end
                        if (sh > newhi_reg)
                        begin
                            newhi_next = sh;
                        end
                        touched_next = 1'b1;
                    end
                    else
                    begin
                        wr1_en = 1'b1;
                        if (!merged_reg)
                        begin
                            wr1_data    = {newlo_reg, newhi_reg};
                            wr2_en      = 1'b1;
                            merged_next = 1'b1;
                        end
                    end
                end
                srst_pkg::OP_ERASE:
                begin
                    if (!found_reg && sl <= lo_reg && lo_reg <= sh)
                    begin
                        found_next = 1'b1;
                        if (sl == lo_reg && sh == lo_reg)
                        begin
                            wr1_en = 1'b0;
                        end
                        else if (sl == lo_reg)
                        begin
                            wr1_en   = 1'b1;
                            wr1_data = {lo_reg + 1'b1, sh};
                        end
                        else if (sh == lo_reg)
                        begin
                            wr1_en   = 1'b1;
                            wr1_data = {sl, lo_reg - 1'b1};
                        end
                        else
                        begin
                            wr1_en     = 1'b1;
                            wr1_data   = {sl, lo_reg - 1'b1};
                            wr2_en     = 1'b1;
                            wr2_data   = {lo_reg + 1'b1, sh};
                            split_next = 1'b1;
                        end
                    end
                    else
                    begin
                        wr1_en = 1'b1;
                    end
                end
                srst_pkg::OP_REPORT:
                begin
                    if (idx_reg != '0 && prev_reg != SEQ_TOP && prev_reg + 1'b1 < sl)
                    begin
                        gap_en = 1'b1;
                        gap_lo = prev_reg + 1'b1;
                        gap_hi = sl - 1'b1;
                    end
                end
                default:
                begin
                    gap_en = 1'b0;
                end
            endcase
        end
        else if (cmd.in_tail && op_reg == srst_pkg::OP_INSERT)
        begin
            if (!merged_reg)
            begin
                wr1_en      = 1'b1;
                wr1_data    = {newlo_reg, newhi_reg};
                merged_next = 1'b1;
            end
            if (more_reg && cur_reg <= hi_reg)
            begin
                gap_en = 1'b1;
                gap_lo = cur_reg;
                gap_hi = hi_reg;
            end
        end
    end

    assign out_free = !out_valid_reg || !rsp_stall;
    assign block    = cmd.in_final ? !out_free : (gap_en && pend_valid_reg && !out_free);
    assign go_scan  = cmd.in_scan && !block;
    assign go_tail  = cmd.in_tail && !block;
    assign go_final = cmd.in_final && !block;
    assign accept   = cmd.in_idle && req_valid;

    // closing word of the item
    assign ins_full = !touched_reg && (cnt_reg == MAX_CNT);
    always_comb
    begin
        commit     = 1'b0;
        final_word = srst_pkg::make_word(srst_pkg::ST_REPORT, 1'b0, '0, '0, 1'b1);
        case (op_reg)
            srst_pkg::OP_INSERT:
            begin
                if (ins_full)
                begin
                    final_word = srst_pkg::make_word(srst_pkg::ST_FULL, 1'b0, '0, '0, 1'b1);
                end
                else if (pend_valid_reg)
                begin
                    final_word      = pend_reg;
                    final_word.last = 1'b1;
                    commit          = 1'b1;
                end
                else
                begin
                    final_word = srst_pkg::make_word(srst_pkg::ST_PRESENT, 1'b0, '0, '0, 1'b1);
                end
            end
            srst_pkg::OP_ERASE:
            begin
                if (!found_reg)
                begin
                    final_word = srst_pkg::make_word(srst_pkg::ST_NOT_FOUND, 1'b0, '0, '0,
                                                     1'b1);
                end
                else if (split_reg && cnt_reg == MAX_CNT)
                begin
                    final_word = srst_pkg::make_word(srst_pkg::ST_FULL, 1'b0, '0, '0, 1'b1);
                end
                else
                begin
                    final_word = srst_pkg::make_word(srst_pkg::ST_ERASED, 1'b0, '0, '0, 1'b1);
                    commit     = 1'b1;
                end
            end
            default:
            begin
                if (pend_valid_reg)
                begin
                    final_word      = pend_reg;
                    final_word.last = 1'b1;
                end
            end
        endcase
    end

    assign push      = go_final || ((go_scan || go_tail) && gap_en && pend_valid_reg);
    assign push_word = go_final ? final_word : pend_reg;

    // table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.in_read)
        begin
            rd_reg <= tbl_mem[{bank_reg, idx_reg[IW-1:0]}];
        end
        if (wptr_reg < MAX_CNT)
        begin
            if ((go_scan || go_tail) && wr1_en)
            begin
                tbl_mem[{~bank_reg, wptr_reg[IW-1:0]}] <= wr1_data;
            end
            else if (cmd.in_write2)
            begin
                tbl_mem[{~bank_reg, wptr_reg[IW-1:0]}] <= wr2_reg;
            end
        end
    end

    // item working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.opcode;
            lo_reg    <= lo_s;
            hi_reg    <= hi_s;
            cur_reg   <= lo_s;
            newlo_reg <= lo_s;
            newhi_reg <= hi_s;
        end
        else if (go_scan || go_tail)
        begin
            cur_reg   <= cur_next;
            newlo_reg <= newlo_next;
            newhi_reg <= newhi_next;
        end
        if (go_scan)
        begin
            prev_reg <= sh;
            if (wr2_en)
            begin
                wr2_reg <= wr2_data;
            end
        end
        if (go_scan || go_tail)
        begin
            if (gap_en)
            begin
                pend_reg <= srst_pkg::make_word(gap_status, 1'b1,
                                                srst_pkg::SEQ_W'(gap_lo),
                                                srst_pkg::SEQ_W'(gap_hi), 1'b0);
            end
        end
        if (push)
        begin
            out_reg <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            more_reg       <= 1'b0;
            touched_reg    <= 1'b0;
            merged_reg     <= 1'b0;
            found_reg      <= 1'b0;
            split_reg      <= 1'b0;
            idx_reg        <= '0;
            wptr_reg       <= '0;
            cnt_reg        <= '0;
            bank_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                more_reg       <= 1'b1;
                touched_reg    <= 1'b0;
                merged_reg     <= 1'b0;
                found_reg      <= 1'b0;
                split_reg      <= 1'b0;
                idx_reg        <= '0;
                wptr_reg       <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (go_scan || go_tail)
                begin
                    more_reg    <= more_next;
                    touched_reg <= touched_next;
                    merged_reg  <= merged_next;
                    found_reg   <= found_next;
                    split_reg   <= split_next;
                    if (gap_en)
                    begin
                        pend_valid_reg <= 1'b1;
                    end
                end
                if (go_scan)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if ((((go_scan || go_tail) && wr1_en) || cmd.in_write2)
                    && wptr_reg < MAX_CNT)
                begin
                    wptr_reg <= wptr_reg + 1'b1;
                end
                if (go_final && commit)
                begin
                    bank_reg <= ~bank_reg;
                    cnt_reg  <= wptr_reg;
                end
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign st.start       = req_valid && cmd.in_idle && (req.opcode != srst_pkg::OP_NONE);
    assign st.table_empty = (cnt_reg == '0);
    assign st.need_write2 = wr2_en;
    assign st.next_done   = (idx_reg + 1'b1 == cnt_reg);
    assign st.idx_done    = (idx_reg == cnt_reg);
    assign st.block       = block;

endmodule

@@ rtl/core/sequence_range_set_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_range_set_tracker
// Sorted table of disjoint sequence-number ranges: insert with gap output,
// single-number erase and missing-range report.
// ----------------------------------------------------------------------------
//   channel  | signals                    | word
//   ---------+----------------------------+---------------------------------
//   request  | req_valid, req_stall, req  | opcode, range_low, range_high
//   response | rsp_valid, rsp_stall, rsp  | status, span_valid, span, last
//
// an operation reads each stored range once through the single table read
//   port, with an extra write step when a new or merged range or an erase
//   split needs a second write
// the table is copied entry by entry into the idle bank and the banks swap
//   only on success, so a full or unmatched operation leaves the table intact
// reset empties the table at once (entry count to zero), no clearing pass
// response stalls hold the scan or tail only when a second gap word is ready,
//   and hold the closing word until the output register is free
// ----------------------------------------------------------------------------
module sequence_range_set_tracker
#(
    parameter int MAX_RANGES = 16,
    parameter int SEQ_BITS   = 63
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  srst_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output srst_pkg::rsp_word_t rsp
);

    // controller to datapath state flags, datapath to controller status
    srst_pkg::srst_cmd_t  cmd;
    srst_pkg::srst_stat_t st;

    // sequencer: accept, per-entry read and scan, tail, final word
    srst_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // two-bank table, scan arithmetic and output register
    srst_dpath
    #(
        .MAX_RANGES (MAX_RANGES),
        .SEQ_BITS   (SEQ_BITS)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .req_valid (req_valid),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // a new request word is taken only between operations
    assign req_stall = !cmd.in_idle;

endmodule

@@ tb/sequence_range_set_tracker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_range_set_tracker_tb
// Drives insert, erase, report and no-op words into the range set tracker under
// random idling on both channels, predicts every response word from a model
// of the range table kept here, and compares each response field by field.
// ----------------------------------------------------------------------------

// predicts and checks response words
class range_set_scoreboard;
    localparam int DEPTH = 16;
    localparam logic [62:0] TOP = {63{1'b1}};

    logic [62:0] tbl_low [DEPTH];
    logic [62:0] tbl_high[DEPTH];
    int          num_ranges;
    srst_pkg::rsp_word_t pending_words[$];
    int          error_count;

    function new();
        num_ranges  = 0;
        error_count = 0;
    endfunction

    function void push_word(logic [2:0] st, logic vld, logic [62:0] lo, logic [62:0] hi);
        srst_pkg::rsp_word_t w;
        w.status     = st;
        w.span_valid = vld;
        w.span_low   = vld ? lo : '0;
        w.span_high  = vld ? hi : '0;
        w.last       = 1'b0;
        pending_words = {pending_words, w};
    endfunction

    function void predict_insert(logic [62:0] lo_in, logic [62:0] hi_in);
        logic [62:0] lo, hi, cur, gh, nlo, nhi;
        int a, b, n, removed;
        bit more;
        lo = lo_in;
        hi = hi_in;
        if (hi < lo)
        begin
            lo = hi_in;
            hi = lo_in;
        end
        for (int i = 0; i < num_ranges; i++)
            if (tbl_low[i] <= lo && tbl_high[i] >= hi)
            begin
                push_word(srst_pkg::ST_PRESENT, 0, 0, 0);
                return;
            end
        a = 0;
        while (a < num_ranges && !(lo == 0 || tbl_high[a] >= lo - 1))
            a++;
        b = a;
        while (b < num_ranges && (hi == TOP || tbl_low[b] <= hi + 1))
            b++;
        if (b == a && num_ranges >= DEPTH)
        begin
            push_word(srst_pkg::ST_FULL, 0, 0, 0);
            return;
        end
        n = 0;
        cur = lo;
        more = 1;
        for (int i = a; i < b && more; i++)
        begin
            if (tbl_low[i] > cur && cur <= hi)
            begin
                gh = tbl_low[i] - 1;
                push_word(srst_pkg::ST_INSERTED, 1, cur, gh < hi ? gh : hi);
                n++;
            end
            if (tbl_high[i] >= cur)
            begin
                if (tbl_high[i] == TOP)
                    more = 0;
                else
                    cur = tbl_high[i] + 1;
            end
        end
        if (more && cur <= hi)
        begin
            push_word(srst_pkg::ST_INSERTED, 1, cur, hi);
            n++;
        end
        if (n == 0)
        begin
            push_word(srst_pkg::ST_PRESENT, 0, 0, 0);
            return;
        end
        nlo = (b > a && tbl_low[a] < lo) ? tbl_low[a] : lo;
        nhi = (b > a && tbl_high[b-1] > hi) ? tbl_high[b-1] : hi;
        if (b == a)
        begin
            for (int i = num_ranges; i > a; i--)
            begin
                tbl_low[i]  = tbl_low[i-1];
                tbl_high[i] = tbl_high[i-1];
            end
            num_ranges++;
        end
        else
        begin
            removed = b - a;
            for (int i = b; i < num_ranges; i++)
            begin
                tbl_low[i-removed+1]  = tbl_low[i];
                tbl_high[i-removed+1] = tbl_high[i];
            end
            num_ranges -= removed - 1;
        end
        tbl_low[a]  = nlo;
        tbl_high[a] = nhi;
    endfunction

    function void predict_erase(logic [62:0] v);
        int idx;
        idx = 0;
        while (idx < num_ranges && !(tbl_low[idx] <= v && tbl_high[idx] >= v))
            idx++;
        if (idx >= num_ranges)
        begin
            push_word(srst_pkg::ST_NOT_FOUND, 0, 0, 0);
            return;
        end
        if (tbl_low[idx] == v && tbl_high[idx] == v)
        begin
            for (int i = idx + 1; i < num_ranges; i++)
            begin
                tbl_low[i-1]  = tbl_low[i];
                tbl_high[i-1] = tbl_high[i];
            end
            num_ranges--;
        end
        else if (tbl_low[idx] == v)
            tbl_low[idx] = v + 1;
        else if (tbl_high[idx] == v)
            tbl_high[idx] = v - 1;
        else
        begin
            if (num_ranges >= DEPTH)
            begin
                push_word(srst_pkg::ST_FULL, 0, 0, 0);
                return;
            end
            for (int i = num_ranges; i > idx + 1; i--)
            begin
                tbl_low[i]  = tbl_low[i-1];
                tbl_high[i] = tbl_high[i-1];
            end
            tbl_low[idx+1]  = v + 1;
            tbl_high[idx+1] = tbl_high[idx];
            tbl_high[idx]   = v - 1;
            num_ranges++;
        end
        push_word(srst_pkg::ST_ERASED, 0, 0, 0);
    endfunction

    function void predict_report();
        int n;
        n = 0;
        for (int i = 0; i + 1 < num_ranges; i++)
            if (tbl_high[i] < TOP && tbl_low[i+1] > 0
                && tbl_high[i] + 1 <= tbl_low[i+1] - 1)
            begin
                push_word(srst_pkg::ST_REPORT, 1, tbl_high[i] + 1, tbl_low[i+1] - 1);
                n++;
            end
        if (n == 0)
            push_word(srst_pkg::ST_REPORT, 0, 0, 0);
    endfunction

    // note an accepted request word and queue its responses
    function void note_request(srst_pkg::req_word_t r);
        int before_n;
        before_n = pending_words.size();
        case (r.opcode)
            srst_pkg::OP_INSERT: predict_insert(r.range_low, r.range_high);
            srst_pkg::OP_ERASE:  predict_erase(r.range_low);
            srst_pkg::OP_REPORT: predict_report();
            default: ;
        endcase
        if (pending_words.size() > before_n)
            pending_words[pending_words.size()-1].last = 1'b1;
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // compare one response word with the oldest prediction
    task check_response(srst_pkg::rsp_word_t got);
        srst_pkg::rsp_word_t exp_w;
        if (pending_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h", got));
            return;
        end
        exp_w = pending_words.pop_front();
        if (got.status !== exp_w.status)
            report_mismatch($sformatf("status %0d want %0d", got.status, exp_w.status));
        if (got.span_valid !== exp_w.span_valid)
            report_mismatch($sformatf("span_valid %0b want %0b", got.span_valid,
                                      exp_w.span_valid));
        if (got.span_low !== exp_w.span_low)
            report_mismatch($sformatf("span_low %h want %h", got.span_low, exp_w.span_low));
        if (got.span_high !== exp_w.span_high)
            report_mismatch($sformatf("span_high %h want %h", got.span_high,
                                      exp_w.span_high));
        if (got.last !== exp_w.last)
            report_mismatch($sformatf("last %0b want %0b", got.last, exp_w.last));
    endtask
endclass

module sequence_range_set_tracker_tb;

    localparam logic [62:0] TOP = {63{1'b1}};

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    srst_pkg::req_word_t req;
    logic                rsp_valid;
    logic                rsp_stall;
    srst_pkg::rsp_word_t rsp;

    // idle rates in percent for each channel, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    range_set_scoreboard sb;

    sequence_range_set_tracker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // response side: random stall, check each accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // present one request word, hold it until accepted, optional gap first
    task automatic send_word(logic [1:0] op, logic [62:0] lo, logic [62:0] hi);
        srst_pkg::req_word_t w;
        w.opcode     = op;
        w.range_low  = lo;
        w.range_high = hi;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(w);
    endtask

    // numbers clustered in a small window so ranges overlap and touch
    function automatic logic [62:0] near_value(logic [62:0] base);
        return base + 63'($urandom_range(200));
    endfunction

    // full-width random number so every bit toggles
    function automatic logic [62:0] wide_value();
        return 63'({$urandom(), $urandom()});
    endfunction

    task automatic random_word(logic [62:0] base);
        int          pick;
        logic [62:0] lo;
        pick = $urandom_range(99);
        lo   = near_value(base);
        if (pick < 50)
            send_word(srst_pkg::OP_INSERT, lo, lo + 63'($urandom_range(12)));
        else if (pick < 55)
            send_word(srst_pkg::OP_INSERT, lo, lo - 63'($urandom_range(5)));
        else if (pick < 80)
            send_word(srst_pkg::OP_ERASE, lo, wide_value());
        else if (pick < 90)
            send_word(srst_pkg::OP_REPORT, wide_value(), wide_value());
        else if (pick < 94)
            send_word(srst_pkg::OP_NONE, wide_value(), wide_value());
        else if (pick < 97)
            send_word(srst_pkg::OP_INSERT, wide_value(), wide_value());
        else
            send_word(srst_pkg::OP_ERASE, wide_value(), wide_value());
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 55;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, reversed bounds, merges, splits
        send_word(srst_pkg::OP_REPORT, 0, 0);
        send_word(srst_pkg::OP_ERASE, 5, 0);
        send_word(srst_pkg::OP_INSERT, 0, 0);
        send_word(srst_pkg::OP_INSERT, TOP, TOP);
        send_word(srst_pkg::OP_INSERT, TOP - 1, TOP);
        send_word(srst_pkg::OP_INSERT, 20, 10);
        send_word(srst_pkg::OP_INSERT, 12, 14);
        send_word(srst_pkg::OP_INSERT, 30, 40);
        send_word(srst_pkg::OP_REPORT, 0, 0);
        send_word(srst_pkg::OP_INSERT, 5, 35);
        send_word(srst_pkg::OP_INSERT, 1, 4);
        send_word(srst_pkg::OP_ERASE, 20, 0);
        send_word(srst_pkg::OP_ERASE, 0, 0);
        send_word(srst_pkg::OP_ERASE, 40, 0);
        send_word(srst_pkg::OP_ERASE, TOP, 0);
        send_word(srst_pkg::OP_NONE, TOP, TOP);
        send_word(srst_pkg::OP_REPORT, 0, 0);
        // fill up to sixteen ranges, then overflow by insert and by split
        for (int i = 0; i < 16; i++)
            send_word(srst_pkg::OP_INSERT, 63'(1000 + 10 * i), 63'(1002 + 10 * i));
        send_word(srst_pkg::OP_INSERT, 5000, 5001);
        send_word(srst_pkg::OP_ERASE, 1001, 0);
        send_word(srst_pkg::OP_REPORT, 0, 0);
        send_word(srst_pkg::OP_INSERT, 0, TOP);
        send_word(srst_pkg::OP_ERASE, 77, 0);
        drain();

        // random phases with the idle rates swapped and then off
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 10 : 0;
            for (int i = 0; i < 100; i++)
            begin
                // clear out every so often to keep the table turning over
                if (i % 40 == 0)
                    send_word(srst_pkg::OP_INSERT, 0, TOP);
                if (i % 40 == 1)
                    send_word(srst_pkg::OP_ERASE, 0, 0);
                random_word(63'(phase) * 1000 + 500);
            end
            drain();
        end

        if (sb.error_count == 0)
            $display("sequence_range_set_tracker_tb: PASS");
        else
            $display("sequence_range_set_tracker_tb: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("sequence_range_set_tracker_tb: FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/srst_pkg.sv
rtl/core/srst_ctrl.sv
rtl/core/srst_dpath.sv
rtl/core/sequence_range_set_tracker.sv
tb/sequence_range_set_tracker_tb.sv
